// ===== rtl/wsm_pkg.sv =====
// Types, codes and constants shared by the window-sum maximum block.
package wsm_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int IDX_W            = 10;
   localparam int DATA_W           = 16;
   localparam int OUT_W            = 26;
   localparam int REG_W            = 11;
   localparam int APB_DATA_W       = 32;
   localparam int APB_ADDR_W       = 3;

   localparam logic [1:0] FN_SET    = 2'd0;
   localparam logic [1:0] FN_SWAP   = 2'd1;
   localparam logic [1:0] FN_QUERY  = 2'd2;
   localparam logic [1:0] FN_UNUSED = 2'd3;

   localparam logic REG_WINDOW_LEN    = 1'b0;
   localparam logic REG_ELEMENT_COUNT = 1'b1;

   localparam logic [REG_W-1:0] WINDOW_LEN_RST    = 11'd1;
   localparam logic [REG_W-1:0] ELEMENT_COUNT_RST = 11'd1024;

   typedef struct packed {
      logic [1:0]               func;
      logic [IDX_W-1:0]         index_a;
      logic [IDX_W-1:0]         index_b;
      logic signed [DATA_W-1:0] new_value;
   } req_item_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] max_sum;
      logic                    range_empty;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_WRB,
      ST_ADJ_SET,
      ST_ADJ,
      ST_QRY,
      ST_QDONE,
      ST_RB_SUM,
      ST_RB_SLIDE
   } state_type;

endpackage

// ===== rtl/window_sum_max_segment_tree.sv =====
// Window-sum maximum block: element memory, window-sum memory and sequencer.
// A register write sets off a rebuild of the window sums once the block is idle.
// Throughput: one item at a time; an update or query pass moves one window sum per cycle
// through the single read port of the window-sum memory (read, add or compare, write back).
// Reset (synchronous, active high) starts a clearing pass over both memories; no item is
// accepted until it ends, register writes are taken throughout.
module window_sum_max_segment_tree
   import wsm_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Address, count, extended-index and window-sum widths.
   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int NW = $clog2(MAX_ELEMENTS + 1);
   localparam int EW = (NW > IDX_W) ? NW + 1 : IDX_W + 1;
   localparam int SW = DATA_W + AW + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);
   localparam logic [EW-1:0] MAX_E     = EW'(MAX_ELEMENTS);
   localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

   // Memories: elements (two read ports) and window sums (one read port).
   logic [DATA_W-1:0]        elem_mem [MAX_ELEMENTS];
   logic signed [SW-1:0]     sum_mem  [MAX_ELEMENTS];

   logic                     ew_en;
   logic [AW-1:0]            ew_addr;
   logic [DATA_W-1:0]        ew_data;
   logic [AW-1:0]            er0_addr;
   logic [AW-1:0]            er1_addr;
   logic signed [DATA_W-1:0] er0_ff;
   logic signed [DATA_W-1:0] er1_ff;
   logic                     sw_en;
   logic [AW-1:0]            sw_addr;
   logic signed [SW-1:0]     sw_data;
   logic [AW-1:0]            sr_addr;
   logic signed [SW-1:0]     sr_ff;

   state_type                state_ff, state_in;
   logic                     pend_ff, pend_in;
   logic [1:0]               op_ff, op_in;
   logic [IDX_W-1:0]         a_ff, a_in;
   logic [IDX_W-1:0]         b_ff, b_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W:0]   diff_ff, diff_in;
   logic signed [DATA_W-1:0] tmp_ff, tmp_in;
   logic                     pass2_ff, pass2_in;
   logic [NW-1:0]            rd_ff, rd_in;
   logic [NW-1:0]            hi_ff, hi_in;
   logic                     pv_ff, pv_in;
   logic [NW-1:0]            pw_ff, pw_in;
   logic signed [SW-1:0]     acc_ff, acc_in;
   logic                     empty_ff, empty_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;
   logic [REG_W-1:0]         cfg_k_ff, cfg_n_ff;

   logic                     cfg_wr;
   logic [EW-1:0]            k_e, n_e, wc_e, a_e, b_e, bq_e, pos_e, lo_e, hi_e, last_e;
   logic [NW-1:0]            k_w, wc_w;
   logic                     set_ok, swap_ok, q_empty, issue;
   logic signed [DATA_W:0]   pdiff;
   logic signed [SW-1:0]     slide_sum;

   // Configuration port: registers read back as written, effective values clamped.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[2])
         REG_WINDOW_LEN:    prdata = APB_DATA_W'(cfg_k_ff);
         REG_ELEMENT_COUNT: prdata = APB_DATA_W'(cfg_n_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_k_ff <= WINDOW_LEN_RST;
         cfg_n_ff <= ELEMENT_COUNT_RST;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_WINDOW_LEN:    cfg_k_ff <= pwdata[REG_W-1:0];
            REG_ELEMENT_COUNT: cfg_n_ff <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one, anything above the array size acts as the array size.
   always_comb begin
      if (cfg_k_ff == '0)                   k_e = EW'(1);
      else if (EW'(cfg_k_ff) > MAX_E)       k_e = MAX_E;
      else                                  k_e = EW'(cfg_k_ff);
      if (cfg_n_ff == '0)                   n_e = EW'(1);
      else if (EW'(cfg_n_ff) > MAX_E)       n_e = MAX_E;
      else                                  n_e = EW'(cfg_n_ff);
      wc_e = (n_e >= k_e) ? n_e - k_e + EW'(1) : '0;
      k_w  = k_e[NW-1:0];
      wc_w = wc_e[NW-1:0];
   end

   // Item decode: validity, clamped query bounds and the window span of one element.
   always_comb begin
      a_e     = EW'(a_ff);
      b_e     = EW'(b_ff);
      set_ok  = a_e < n_e;
      swap_ok = (a_e < n_e) && (b_e < n_e) && (a_ff != b_ff);
      bq_e    = (b_e >= n_e) ? n_e - EW'(1) : b_e;
      last_e  = bq_e + EW'(1) - k_e;
      q_empty = (wc_e == '0) || (bq_e + EW'(1) < k_e) || (a_e > last_e);
      pos_e   = pass2_ff ? b_e : a_e;
      lo_e    = (pos_e + EW'(1) >= k_e) ? pos_e + EW'(1) - k_e : '0;
      hi_e    = (pos_e < wc_e - EW'(1)) ? pos_e : wc_e - EW'(1);
      pdiff   = pass2_ff ? -diff_ff : diff_ff;
   end

   // Memories: synchronous write, registered read.
   always_ff @(posedge clock) begin
      if (ew_en) elem_mem[ew_addr] <= ew_data;
      er0_ff <= elem_mem[er0_addr];
      er1_ff <= elem_mem[er1_addr];
   end

   always_ff @(posedge clock) begin
      if (sw_en) sum_mem[sw_addr] <= sw_data;
      sr_ff <= sum_mem[sr_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pend_ff      <= 1'b0;
         pv_ff        <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         pv_ff        <= pv_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      val_ff      <= val_in;
      diff_ff     <= diff_in;
      tmp_ff      <= tmp_in;
      pass2_ff    <= pass2_in;
      rd_ff       <= rd_in;
      hi_ff       <= hi_in;
      pw_ff       <= pw_in;
      acc_ff      <= acc_in;
      empty_ff    <= empty_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Sequencer: an update pass reads one window sum per cycle, writes it back the next cycle.
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      val_in       = val_ff;
      diff_in      = diff_ff;
      tmp_in       = tmp_ff;
      pass2_in     = pass2_ff;
      rd_in        = rd_ff;
      hi_in        = hi_ff;
      pv_in        = 1'b0;
      pw_in        = rd_ff;
      acc_in       = acc_ff;
      empty_in     = empty_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      ew_en        = 1'b0;
      ew_addr      = AW'(a_ff);
      ew_data      = val_ff;
      er0_addr     = AW'(a_ff);
      er1_addr     = AW'(b_ff);
      sw_en        = 1'b0;
      sw_addr      = AW'(pw_ff);
      sw_data      = sr_ff + SW'(pdiff);
      sr_addr      = AW'(rd_ff);
      issue        = rd_ff <= hi_ff;
      slide_sum    = acc_ff + SW'(er0_ff) - SW'(er1_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero both memories, one entry a cycle.
            ew_en   = 1'b1;
            ew_addr = clr_ff;
            ew_data = '0;
            sw_en   = 1'b1;
            sw_addr = clr_ff;
            sw_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pend_ff) begin
               // Rebuild window sums after a register write.
               pend_in = 1'b0;
               rd_in   = '0;
               acc_in  = '0;
               if (wc_w != '0) state_in = ST_RB_SUM;
            end else if (req_valid) begin
               op_in    = req_item.func;
               a_in     = req_item.index_a;
               b_in     = req_item.index_b;
               val_in   = req_item.new_value;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            pass2_in = 1'b0;
            case (op_ff)
               FN_SET:  state_in = set_ok ? ST_DIFF : ST_IDLE;
               FN_SWAP: state_in = swap_ok ? ST_DIFF : ST_IDLE;
               FN_QUERY: begin
                  empty_in = q_empty;
                  rd_in    = a_e[NW-1:0];
                  hi_in    = last_e[NW-1:0];
                  acc_in   = SUM_MIN;
                  state_in = q_empty ? ST_QDONE : ST_QRY;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIFF: begin
            ew_en = 1'b1;
            if (op_ff == FN_SWAP) begin
               ew_data  = er1_ff;
               diff_in  = (DATA_W+1)'(er1_ff) - (DATA_W+1)'(er0_ff);
               tmp_in   = er0_ff;
               state_in = ST_WRB;
            end else begin
               diff_in  = (DATA_W+1)'(val_ff) - (DATA_W+1)'(er0_ff);
               state_in = ST_ADJ_SET;
            end
         end
         ST_WRB: begin
            ew_en    = 1'b1;
            ew_addr  = AW'(b_ff);
            ew_data  = tmp_ff;
            state_in = ST_ADJ_SET;
         end
         ST_ADJ_SET: begin
            if (wc_w == '0 || diff_ff == '0) begin
               if (op_ff == FN_SWAP && !pass2_ff) pass2_in = 1'b1;
               else                               state_in = ST_IDLE;
            end else begin
               rd_in    = lo_e[NW-1:0];
               hi_in    = hi_e[NW-1:0];
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            if (issue) begin
               pv_in = 1'b1;
               rd_in = rd_ff + NW'(1);
            end
            if (pv_ff) sw_en = 1'b1;
            if (!issue && !pv_ff) begin
               if (op_ff == FN_SWAP && !pass2_ff) begin
                  pass2_in = 1'b1;
                  state_in = ST_ADJ_SET;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_QRY: begin
            if (issue) begin
               pv_in = 1'b1;
               rd_in = rd_ff + NW'(1);
            end
            if (pv_ff && sr_ff > acc_ff) acc_in = sr_ff;
            if (!issue && !pv_ff) state_in = ST_QDONE;
         end
         ST_QDONE: begin
            // Hold the result until the output register frees up.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.max_sum     = empty_ff ? '0 : OUT_W'(acc_ff);
               rsp_item_in.range_empty = empty_ff;
               state_in                = ST_IDLE;
            end
         end
         ST_RB_SUM: begin
            // First window: plain sum of the leading elements.
            er0_addr = AW'(rd_ff);
            if (rd_ff < k_w) begin
               pv_in = 1'b1;
               rd_in = rd_ff + NW'(1);
            end
            if (pv_ff) acc_in = acc_ff + SW'(er0_ff);
            if (!(rd_ff < k_w) && !pv_ff) begin
               sw_en    = 1'b1;
               sw_addr  = '0;
               sw_data  = acc_ff;
               rd_in    = NW'(1);
               state_in = (wc_w > NW'(1)) ? ST_RB_SLIDE : ST_IDLE;
            end
         end
         ST_RB_SLIDE: begin
            // Slide: add the entering element, drop the leaving one.
            er0_addr = AW'(rd_ff + k_w - NW'(1));
            er1_addr = AW'(rd_ff - NW'(1));
            if (rd_ff < wc_w) begin
               pv_in = 1'b1;
               rd_in = rd_ff + NW'(1);
            end
            if (pv_ff) begin
               acc_in  = slide_sum;
               sw_en   = 1'b1;
               sw_data = slide_sum;
            end
            if (!(rd_ff < wc_w) && !pv_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (cfg_wr) pend_in = 1'b1;
   end

   assign req_stall = !(state_ff == ST_IDLE && !pend_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   // A result appears only when a query finishes.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QDONE))
      else $error("result raised outside query completion");

   // Every read-modify-write lands on the entry read in the cycle before.
   a_adj_same_entry: assert property (@(posedge clock) disable iff (reset)
      (sw_en && state_ff == ST_ADJ) |-> (sw_addr == $past(sr_addr)))
      else $error("window update written to wrong entry");

   // Leaving reset always begins with the clearing pass.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == ST_CLEAR && req_stall))
      else $error("clearing pass skipped after reset");
`endif

endmodule

// ===== bench/wsm_window_monitor.sv =====
// Monitor for the window-sum maximum block: tracks elements and registers, predicts query results.
`timescale 1ns / 100ps

module wsm_window_monitor
   import wsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_item_type          req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output int                    mismatch_count,
   output int                    pending_count
);

   logic signed [DATA_W-1:0] elements [MAX_ELEMENTS_DEF];
   logic [REG_W-1:0]         win_len_reg;
   logic [REG_W-1:0]         elem_cnt_reg;
   rsp_item_type             sums_due [$];
   int                       errors;

   // Zero acts as one, anything past the array size acts as the array size.
   function automatic int effective(logic [REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_ELEMENTS_DEF) return MAX_ELEMENTS_DEF;
      return int'(v);
   endfunction

   function automatic rsp_item_type window_max(int first, int last_pos);
      int           k;
      int           n;
      int           last_win;
      longint       acc;
      longint       best;
      rsp_item_type r;
      k = effective(win_len_reg);
      n = effective(elem_cnt_reg);
      r.max_sum     = '0;
      r.range_empty = 1'b1;
      if (last_pos >= n) last_pos = n - 1;
      if (n < k || last_pos + 1 < k) return r;
      last_win = last_pos + 1 - k;
      if (first > last_win) return r;
      acc = 0;
      for (int i = first; i < first + k; i++) acc += elements[i];
      best = acc;
      for (int w = first + 1; w <= last_win; w++) begin
         acc += elements[w + k - 1] - elements[w - 1];
         if (acc > best) best = acc;
      end
      r.max_sum     = best[OUT_W-1:0];
      r.range_empty = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type exp_item;
      logic signed [DATA_W-1:0] held;
      int n;
      if (reset) begin
         for (int i = 0; i < MAX_ELEMENTS_DEF; i++) elements[i] = '0;
         win_len_reg  = WINDOW_LEN_RST;
         elem_cnt_reg = ELEMENT_COUNT_RST;
         sums_due.delete();
      end else begin
         // compare results first: a result never belongs to an item taken this edge
         if (rsp_valid && !rsp_stall) begin
            if (sums_due.size() == 0) begin
               $error("unexpected result: max_sum %0d range_empty %0b",
                      rsp_item.max_sum, rsp_item.range_empty);
               errors++;
            end else begin
               exp_item = sums_due.pop_front();
               if (rsp_item.max_sum !== exp_item.max_sum) begin
                  $error("max_sum: expected %0d, got %0d", exp_item.max_sum, rsp_item.max_sum);
                  errors++;
               end
               if (rsp_item.range_empty !== exp_item.range_empty) begin
                  $error("range_empty: expected %0b, got %0b",
                         exp_item.range_empty, rsp_item.range_empty);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            n = effective(elem_cnt_reg);
            case (req_item.func)
               FN_SET: begin
                  if (req_item.index_a < n) elements[req_item.index_a] = req_item.new_value;
               end
               FN_SWAP: begin
                  if (req_item.index_a < n && req_item.index_b < n) begin
                     held = elements[req_item.index_a];
                     elements[req_item.index_a] = elements[req_item.index_b];
                     elements[req_item.index_b] = held;
                  end
               end
               FN_QUERY: begin
                  sums_due.push_back(window_max(req_item.index_a, req_item.index_b));
               end
               default: ;
            endcase
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_ELEMENT_COUNT) elem_cnt_reg = pwdata[REG_W-1:0];
            else win_len_reg = pwdata[REG_W-1:0];
         end
      end
      pending_count  <= sums_due.size();
      mismatch_count <= errors;
   end

endmodule

// ===== bench/tb_window_sum_max_segment_tree.sv =====
// Top of the window-sum maximum testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_window_sum_max_segment_tree;
   import wsm_pkg::*;

   // Longest quiet time of the block: a swap on the widest window or a rebuild.
   localparam int SETTLE_CYCLES = 2200;
   localparam int HOLD_CYCLES   = 3000;
   localparam int CYCLE_LIMIT   = 10000000;
   localparam int PHASES        = 10;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   rsp_item_type          rsp_item;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [APB_ADDR_W-1:0] paddr     = '0;
   logic [APB_DATA_W-1:0] pwdata    = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   int   mismatch_count;
   int   pending_count;
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   logic hold_go     = 1'b0;
   int   hold_left   = 0;
   int   cycle_count = 0;
   int   cur_count   = MAX_ELEMENTS_DEF;

   window_sum_max_segment_tree i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   wsm_window_monitor i_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_window_sum_max_segment_tree: done, errors");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= hold_go || hold_left > 1 || ($urandom_range(0, 99) < rx_idle_pct);
   end

   // Offer one item; idle at random first, then hold it until the block takes it.
   task automatic send_item(req_item_type item);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until the last query taken has been answered too.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Write one register once the block has gone quiet; upper data bits are noise.
   task automatic csr_write(logic reg_sel, logic [REG_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= {21'($urandom_range(0, 2097151)), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_ELEMENT_COUNT) begin
         cur_count = (value == 0) ? 1 :
                     (int'(value) > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(value);
      end
   endtask

   function automatic req_item_type make_item(logic [1:0] func, int a, int b, int value);
      req_item_type item;
      item.func      = func;
      item.index_a   = a[IDX_W-1:0];
      item.index_b   = b[IDX_W-1:0];
      item.new_value = value[DATA_W-1:0];
      return item;
   endfunction

   // Mostly in-range positions so updates land; the rest anywhere in the index space.
   function automatic int pick_index();
      if ($urandom_range(0, 99) < 88) return $urandom_range(0, cur_count - 1);
      return $urandom_range(0, 1023);
   endfunction

   function automatic req_item_type random_item();
      req_item_type item;
      int roll;
      int a;
      int b;
      roll = $urandom_range(0, 99);
      a = pick_index();
      b = pick_index();
      if (roll >= 60 && roll < 95 && $urandom_range(0, 1)) begin
         // narrow ranges so both empty and single-window queries come up
         b = a + $urandom_range(0, 20);
         if (b > 1023) b = 1023;
      end
      item = make_item(FN_SET, a, b, $urandom);
      case ($urandom_range(0, 9))
         0: item.new_value = 16'sh7fff;
         1: item.new_value = 16'sh8000;
         default: ;
      endcase
      if (roll < 40) item.func = FN_SET;
      else if (roll < 60) item.func = FN_SWAP;
      else if (roll < 95) item.func = FN_QUERY;
      else item.func = FN_UNUSED;
      return item;
   endfunction

   initial begin
      int win_set  [PHASES] = '{1, 2, 3, 2047, 5, 8, 16, 0, 1024, 7};
      int cnt_set  [PHASES] = '{0, 2, 16, 40, 32, 64, 48, 2047, 1024, 24};
      int item_set [PHASES] = '{30, 40, 150, 40, 150, 150, 120, 30, 30, 300};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes at both ends of the full array, window of one.
      tx_idle_pct = 15;
      rx_idle_pct <= 77;
      send_item(make_item(FN_SET, 0, 0, 32767));
      send_item(make_item(FN_SET, 1023, 0, -32768));
      send_item(make_item(FN_QUERY, 0, 1023, 0));
      send_item(make_item(FN_SWAP, 0, 1023, 0));
      send_item(make_item(FN_QUERY, 0, 0, 0));
      send_item(make_item(FN_SWAP, 5, 5, 0));
      send_item(make_item(FN_UNUSED, 7, 9, 123));
      send_item(make_item(FN_QUERY, 10, 3, 0));
      send_item(make_item(FN_QUERY, 1023, 1023, 0));

      // Widest window: one window over the whole array, then a range one short.
      csr_write(REG_WINDOW_LEN, 11'd1024);
      send_item(make_item(FN_QUERY, 0, 1023, 0));
      send_item(make_item(FN_QUERY, 1, 1023, 0));

      // Short array, zero window: out-of-array set and swap, clamped query end.
      csr_write(REG_ELEMENT_COUNT, 11'd10);
      csr_write(REG_WINDOW_LEN, 11'd0);
      send_item(make_item(FN_SET, 12, 0, 555));
      send_item(make_item(FN_SWAP, 3, 12, 0));
      send_item(make_item(FN_SET, 9, 0, -7));
      send_item(make_item(FN_QUERY, 0, 1023, 0));

      // Window longer than the array: nothing fits.
      csr_write(REG_WINDOW_LEN, 11'd20);
      send_item(make_item(FN_QUERY, 0, 9, 0));

      for (int p = 0; p < PHASES; p++) begin
         if (p < 4) begin
            tx_idle_pct = 15;
            rx_idle_pct <= 77;
         end else if (p < 7) begin
            tx_idle_pct = 77;
            rx_idle_pct <= 15;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
         end
         csr_write(REG_WINDOW_LEN, win_set[p][REG_W-1:0]);
         csr_write(REG_ELEMENT_COUNT, cnt_set[p][REG_W-1:0]);
         for (int i = 0; i < item_set[p]; i++) begin
            if (i == 50 && (p == 2 || p == 9)) begin
               // pause the sender until every query is answered
               drain_results();
            end
            if (i == 50 && (p == 4 || p == 7)) begin
               // receiver holds off long while items keep coming
               req_valid <= 1'b0;
               hold_go   <= 1'b1;
               @(posedge clock);
               hold_go   <= 1'b0;
            end
            send_item(random_item());
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_window_sum_max_segment_tree: done, clean");
      end else begin
         $display("tb_window_sum_max_segment_tree: done, errors");
      end
      $finish;
   end

endmodule
